>>> sv/mopg_pkg.sv
// shared types, constants and helpers for the multi-output pwm generator
`timescale 1ns / 1ps
`default_nettype none

package mopg_pkg;

   localparam int NUM_OUTPUTS = 8;
   localparam int PIN_WIDTH   = 8;
   localparam int DATA_WIDTH  = 32;
   localparam int RES_WIDTH   = 16;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   bad;
      logic [DATA_WIDTH-1:0]  period;
      logic [DATA_WIDTH-1:0]  duty;
      logic                   invert;
      logic                   enable;
   } item_type;

   typedef struct packed {
      logic [PIN_WIDTH-1:0]   pins;
      logic                   status;
      logic                   running;
      logic [DATA_WIDTH-1:0]  period;
      logic [DATA_WIDTH-1:0]  duty;
      logic                   invert;
      logic                   enable;
   } result_type;

   // copy the common level onto the outputs that exist
   function automatic logic [PIN_WIDTH-1:0] spread_pin(input logic pin);
      logic [PIN_WIDTH-1:0] value;
      for (int i = 0; i < PIN_WIDTH; i++) begin
         value[i] = pin && (i < NUM_OUTPUTS);
      end
      return value;
   endfunction

endpackage

`default_nettype wire

>>> sv/mopg_front.sv
// front end: resolution register, request check and item queue
`timescale 1ns / 1ps
`default_nettype none

module mopg_front
   import mopg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic                   req_operation,
   input  wire logic [DATA_WIDTH-1:0]  req_period,
   input  wire logic [DATA_WIDTH-1:0]  req_duty,
   input  wire logic                   req_invert,
   input  wire logic                   req_enable,
   input  wire logic                   csr_wr_en,
   input  wire logic [RES_WIDTH-1:0]   csr_wr_data,
   output logic [RES_WIDTH-1:0]        res_eff,
   output item_type                    head,
   output logic                        head_valid,
   input  wire logic                   head_pop
);

   logic [RES_WIDTH-1:0]   resolution_ff;
   item_type               queue_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             count_ff;
   logic                   push_fire;
   logic                   pop_fire;
   logic [DATA_WIDTH-1:0]  res_wide;
   logic [DATA_WIDTH-1:0]  gap;
   item_type               entry;

   assign res_eff    = (resolution_ff == '0) ? RES_WIDTH'(1) : resolution_ff;
   assign res_wide   = {{(DATA_WIDTH-RES_WIDTH){1'b0}}, res_eff};
   assign gap        = req_period - req_duty;
   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push_fire  = push && !full;
   assign pop_fire   = head_pop && head_valid;

   always_comb begin
      entry.op     = op_type'(req_operation);
      entry.bad    = ((req_duty != '0) && (req_duty < res_wide))
                  || (req_duty > req_period)
                  || ((req_duty != req_period) && (gap < res_wide));
      entry.period = req_period;
      entry.duty   = req_duty;
      entry.invert = req_invert;
      entry.enable = req_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff <= RES_WIDTH'(1);
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            resolution_ff <= csr_wr_data;
         end
         if (push_fire) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/mopg_rem.sv
// bit-serial remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module mopg_rem
   import mopg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [DATA_WIDTH-1:0]  dividend,
   input  wire logic [RES_WIDTH-1:0]   divisor,
   output logic                        done,
   output logic [RES_WIDTH-1:0]        remainder
);

   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic [DATA_WIDTH-1:0]  dvd_ff;
   logic [RES_WIDTH-1:0]   div_ff;
   logic [RES_WIDTH-1:0]   rem_ff;
   logic [RES_WIDTH:0]     trial;
   logic [RES_WIDTH:0]     diff;

   assign trial     = {rem_ff, dvd_ff[DATA_WIDTH-1]};
   assign diff      = trial - {1'b0, div_ff};
   assign done      = done_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DATA_WIDTH-2:0], 1'b0};
         rem_ff <= (trial >= {1'b0, div_ff}) ? diff[RES_WIDTH-1:0]
                                              : trial[RES_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

>>> sv/mopg_back.sv
// back end: pwm state, settings update and result queue
`timescale 1ns / 1ps
`default_nettype none

module mopg_back
   import mopg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire item_type               head,
   input  wire logic                   head_valid,
   output logic                        head_pop,
   input  wire logic [RES_WIDTH-1:0]   res_eff,
   output logic                        empty,
   input  wire logic                   pop,
   output result_type                  result
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_APPLY
   } state_type;

   state_type              state_ff, state_in;
   logic [DATA_WIDTH-1:0]  cur_period_ff, cur_period_in;
   logic [DATA_WIDTH-1:0]  cur_duty_ff, cur_duty_in;
   logic                   cur_invert_ff, cur_invert_in;
   logic                   cur_enable_ff, cur_enable_in;
   logic [DATA_WIDTH-1:0]  pend_period_ff, pend_period_in;
   logic [DATA_WIDTH-1:0]  pend_duty_ff, pend_duty_in;
   logic                   pend_invert_ff, pend_invert_in;
   logic                   pend_enable_ff, pend_enable_in;
   logic                   waiting_ff, waiting_in;
   logic                   run_ff, run_in;
   logic                   phase_ff, phase_in;
   logic [DATA_WIDTH-1:0]  remaining_ff, remaining_in;
   logic                   pin_ff, pin_in;
   logic [DATA_WIDTH-1:0]  wr_period_ff, wr_period_in;
   logic [DATA_WIDTH-1:0]  wr_duty_ff, wr_duty_in;
   logic                   wr_invert_ff, wr_invert_in;
   logic                   wr_enable_ff, wr_enable_in;

   logic                   rem_start;
   logic                   rem_done;
   logic                   rem_done_duty;
   logic [RES_WIDTH-1:0]   rem_period;
   logic [RES_WIDTH-1:0]   rem_duty;
   logic                   drive_en;
   logic                   drive_lvl;
   logic                   status;
   logic                   res_push;
   result_type             res_entry;

   result_type             rq_ff [2];
   logic                   rq_wr_ff;
   logic                   rq_rd_ff;
   logic [1:0]             rq_count_ff;
   logic                   rq_full;
   logic                   rq_pop;

   mopg_rem u_rem_period (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (head.period),
      .divisor   (res_eff),
      .done      (rem_done),
      .remainder (rem_period)
   );

   mopg_rem u_rem_duty (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (head.duty),
      .divisor   (res_eff),
      .done      (rem_done_duty),
      .remainder (rem_duty)
   );

   assign rq_full = (rq_count_ff == 2'd2);
   assign empty   = (rq_count_ff == 2'd0);
   assign rq_pop  = pop && !empty;
   assign result  = rq_ff[rq_rd_ff];

   always_comb begin
      state_in       = state_ff;
      cur_period_in  = cur_period_ff;
      cur_duty_in    = cur_duty_ff;
      cur_invert_in  = cur_invert_ff;
      cur_enable_in  = cur_enable_ff;
      pend_period_in = pend_period_ff;
      pend_duty_in   = pend_duty_ff;
      pend_invert_in = pend_invert_ff;
      pend_enable_in = pend_enable_ff;
      waiting_in     = waiting_ff;
      run_in         = run_ff;
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      pin_in         = pin_ff;
      wr_period_in   = wr_period_ff;
      wr_duty_in     = wr_duty_ff;
      wr_invert_in   = wr_invert_ff;
      wr_enable_in   = wr_enable_ff;
      head_pop       = 1'b0;
      rem_start      = 1'b0;
      res_push       = 1'b0;
      status         = 1'b0;
      drive_en       = 1'b0;
      drive_lvl      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid && !rq_full) begin
               head_pop = 1'b1;
               if (head.op == OP_TICK) begin
                  res_push = 1'b1;
                  if (remaining_ff != '0) begin
                     remaining_in = remaining_ff - DATA_WIDTH'(1);
                     if (remaining_ff == DATA_WIDTH'(1)) begin
                        drive_en = 1'b1;
                        if (!phase_ff && waiting_ff) begin
                           waiting_in    = 1'b0;
                           cur_period_in = pend_period_ff;
                           cur_duty_in   = pend_duty_ff;
                           cur_invert_in = pend_invert_ff;
                           cur_enable_in = pend_enable_ff;
                           drive_lvl     = (pend_duty_ff != '0);
                        end else begin
                           drive_lvl = !phase_ff;
                        end
                     end
                  end
               end else if (head.bad) begin
                  res_push = 1'b1;
                  status   = 1'b1;
               end else begin
                  rem_start    = 1'b1;
                  wr_period_in = head.period;
                  wr_duty_in   = head.duty;
                  wr_invert_in = head.invert;
                  wr_enable_in = head.enable;
                  state_in     = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            if (rem_done && rem_done_duty) begin
               wr_period_in = wr_period_ff - {{(DATA_WIDTH-RES_WIDTH){1'b0}}, rem_period};
               wr_duty_in   = wr_duty_ff - {{(DATA_WIDTH-RES_WIDTH){1'b0}}, rem_duty};
               state_in     = S_APPLY;
            end
         end
         S_APPLY: begin
            if (!rq_full) begin
               res_push = 1'b1;
               state_in = S_IDLE;
               if (!wr_enable_ff) begin
                  cur_period_in = wr_period_ff;
                  cur_duty_in   = wr_duty_ff;
                  cur_invert_in = wr_invert_ff;
                  cur_enable_in = 1'b0;
                  run_in        = 1'b0;
                  waiting_in    = 1'b0;
                  remaining_in  = '0;
                  pin_in        = wr_invert_ff;
               end else if (run_ff) begin
                  pend_period_in = wr_period_ff;
                  pend_duty_in   = wr_duty_ff;
                  pend_invert_in = wr_invert_ff;
                  pend_enable_in = 1'b1;
                  waiting_in     = 1'b1;
               end else begin
                  cur_period_in = wr_period_ff;
                  cur_duty_in   = wr_duty_ff;
                  cur_invert_in = wr_invert_ff;
                  cur_enable_in = 1'b1;
                  waiting_in    = 1'b0;
                  drive_en      = 1'b1;
                  drive_lvl     = (wr_duty_ff != '0);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // start a phase at the new level
      if (drive_en) begin
         phase_in = drive_lvl;
         pin_in   = drive_lvl ^ cur_invert_in;
         if ((cur_duty_in == '0) || (cur_duty_in == cur_period_in)) begin
            run_in       = 1'b0;
            remaining_in = '0;
         end else begin
            run_in       = 1'b1;
            remaining_in = drive_lvl ? cur_duty_in : (cur_period_in - cur_duty_in);
         end
      end

      res_entry.pins    = spread_pin(pin_in);
      res_entry.status  = status;
      res_entry.running = run_in;
      res_entry.period  = waiting_in ? pend_period_in : cur_period_in;
      res_entry.duty    = waiting_in ? pend_duty_in : cur_duty_in;
      res_entry.invert  = waiting_in ? pend_invert_in : cur_invert_in;
      res_entry.enable  = waiting_in ? pend_enable_in : cur_enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cur_period_ff  <= '0;
         cur_duty_ff    <= '0;
         cur_invert_ff  <= 1'b0;
         cur_enable_ff  <= 1'b0;
         pend_period_ff <= '0;
         pend_duty_ff   <= '0;
         pend_invert_ff <= 1'b0;
         pend_enable_ff <= 1'b0;
         waiting_ff     <= 1'b0;
         run_ff         <= 1'b0;
         phase_ff       <= 1'b0;
         remaining_ff   <= '0;
         pin_ff         <= 1'b0;
         rq_wr_ff       <= 1'b0;
         rq_rd_ff       <= 1'b0;
         rq_count_ff    <= 2'd0;
      end else begin
         state_ff       <= state_in;
         cur_period_ff  <= cur_period_in;
         cur_duty_ff    <= cur_duty_in;
         cur_invert_ff  <= cur_invert_in;
         cur_enable_ff  <= cur_enable_in;
         pend_period_ff <= pend_period_in;
         pend_duty_ff   <= pend_duty_in;
         pend_invert_ff <= pend_invert_in;
         pend_enable_ff <= pend_enable_in;
         waiting_ff     <= waiting_in;
         run_ff         <= run_in;
         phase_ff       <= phase_in;
         remaining_ff   <= remaining_in;
         pin_ff         <= pin_in;
         if (res_push) begin
            rq_wr_ff <= ~rq_wr_ff;
         end
         if (rq_pop) begin
            rq_rd_ff <= ~rq_rd_ff;
         end
         if (res_push && !rq_pop) begin
            rq_count_ff <= rq_count_ff + 2'd1;
         end else if (rq_pop && !res_push) begin
            rq_count_ff <= rq_count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_period_ff <= wr_period_in;
      wr_duty_ff   <= wr_duty_in;
      wr_invert_ff <= wr_invert_in;
      wr_enable_ff <= wr_enable_in;
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res_entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/multi_output_pwm_generator_top.sv
// top level of the multi-output pwm generator
//
//   channel   ports                     handshake
//   request   push, full, req_*         taken when push and not full
//   response  empty, pop, rsp_*         taken when pop and not empty
//   config    csr_wr_en, csr_wr_data    written when csr_wr_en
//
// ticks and rejected settings transactions are answered in the idle state
// accepted ones pass the divide and apply states, where the two 32-step
// bit-serial remainder units round period and duty down to the resolution
// two-entry queues before and after the back end let each side stall alone
// reset is synchronous and clears the queues and the pwm state; resolution returns to 1
`timescale 1ns / 1ps
`default_nettype none

module multi_output_pwm_generator_top
   import mopg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic                   req_operation,
   input  wire logic [DATA_WIDTH-1:0]  req_period,
   input  wire logic [DATA_WIDTH-1:0]  req_duty,
   input  wire logic                   req_invert,
   input  wire logic                   req_enable,
   output logic                        empty,
   input  wire logic                   pop,
   output logic [PIN_WIDTH-1:0]        rsp_pins,
   output logic                        rsp_status,
   output logic                        rsp_is_running,
   output logic [DATA_WIDTH-1:0]       rsp_rep_period,
   output logic [DATA_WIDTH-1:0]       rsp_rep_duty,
   output logic                        rsp_rep_invert,
   output logic                        rsp_rep_enable,
   input  wire logic                   csr_wr_en,
   input  wire logic [RES_WIDTH-1:0]   csr_wr_data
);

   item_type               head;
   logic                   head_valid;
   logic                   head_pop;
   logic [RES_WIDTH-1:0]   res_eff;
   result_type             result;

   mopg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_period    (req_period),
      .req_duty      (req_duty),
      .req_invert    (req_invert),
      .req_enable    (req_enable),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .res_eff       (res_eff),
      .head          (head),
      .head_valid    (head_valid),
      .head_pop      (head_pop)
   );

   mopg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .res_eff    (res_eff),
      .empty      (empty),
      .pop        (pop),
      .result     (result)
   );

   assign rsp_pins       = result.pins;
   assign rsp_status     = result.status;
   assign rsp_is_running = result.running;
   assign rsp_rep_period = result.period;
   assign rsp_rep_duty   = result.duty;
   assign rsp_rep_invert = result.invert;
   assign rsp_rep_enable = result.enable;

endmodule

`default_nettype wire

>>> bench/tb_multi_output_pwm_generator_top.sv
// self-checking testbench for the multi-output pwm generator top level
`timescale 1ns / 1ps

module tb_multi_output_pwm_generator_top;
   import mopg_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [31:0] LANE_MASK =
      (NUM_OUTPUTS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NUM_OUTPUTS) - 32'd1);
   localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic                  req_operation = 1'b0;
   logic [DATA_WIDTH-1:0] req_period = '0;
   logic [DATA_WIDTH-1:0] req_duty = '0;
   logic                  req_invert = 1'b0;
   logic                  req_enable = 1'b0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [PIN_WIDTH-1:0]  rsp_pins;
   logic                  rsp_status;
   logic                  rsp_is_running;
   logic [DATA_WIDTH-1:0] rsp_rep_period;
   logic [DATA_WIDTH-1:0] rsp_rep_duty;
   logic                  rsp_rep_invert;
   logic                  rsp_rep_enable;
   logic                  csr_wr_en = 1'b0;
   logic [RES_WIDTH-1:0]  csr_wr_data = '0;

   multi_output_pwm_generator_top u_top (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_operation  (req_operation),
      .req_period     (req_period),
      .req_duty       (req_duty),
      .req_invert     (req_invert),
      .req_enable     (req_enable),
      .empty          (empty),
      .pop            (pop),
      .rsp_pins       (rsp_pins),
      .rsp_status     (rsp_status),
      .rsp_is_running (rsp_is_running),
      .rsp_rep_period (rsp_rep_period),
      .rsp_rep_duty   (rsp_rep_duty),
      .rsp_rep_invert (rsp_rep_invert),
      .rsp_rep_enable (rsp_rep_enable),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [RES_WIDTH-1:0]  res_reg = 16'd1;
   logic [DATA_WIDTH-1:0] act_period = '0, act_duty = '0, shd_period = '0, shd_duty = '0;
   logic                  act_invert = 0, act_enable = 0, shd_invert = 0, shd_enable = 0;
   logic                  shd_valid = 0, toggling = 0, level = 0, pin_lvl = 0;
   logic [DATA_WIDTH-1:0] ticks_left = '0;

   item_type   pwm_commands[$];
   result_type pwm_reports[$];
   item_type   next_cmd, seen_cmd;
   result_type exp_rpt, got_rpt;

   logic req_taken = 0, rsp_taken = 0;
   logic calm = 0;
   int   send_gap = 0, pop_gap = 0;
   int   cycle_count = 0, mismatches = 0;
   int   n_accepted = 0, n_writes = 0, n_rejects = 0, n_phase_ends = 0, n_res_settings = 1;

   function automatic void set_level(input logic lv);
      level   = lv;
      pin_lvl = lv ^ act_invert;
      if (act_duty == '0 || act_duty == act_period) begin
         toggling   = 1'b0;
         ticks_left = '0;
      end else begin
         toggling   = 1'b1;
         ticks_left = lv ? act_duty : act_period - act_duty;
      end
   endfunction

   function automatic result_type pwm_advance(input item_type cmd);
      logic [DATA_WIDTH-1:0] res, rp, rd;
      logic                  rej;
      logic                  nxt;
      result_type            r;
      rej = 1'b0;
      if (cmd.op == OP_WRITE) begin
         n_writes++;
         res = (res_reg == '0) ? 1 : DATA_WIDTH'(res_reg);
         if ((cmd.duty != '0 && cmd.duty < res) || cmd.duty > cmd.period ||
             (cmd.duty != cmd.period && cmd.period - cmd.duty < res)) begin
            rej = 1'b1;
            n_rejects++;
         end else begin
            rp = cmd.period - (cmd.period % res);
            rd = cmd.duty - (cmd.duty % res);
            if (!cmd.enable) begin
               act_period = rp;
               act_duty   = rd;
               act_invert = cmd.invert;
               act_enable = 1'b0;
               toggling   = 1'b0;
               shd_valid  = 1'b0;
               ticks_left = '0;
               pin_lvl    = cmd.invert;
            end else if (toggling) begin
               shd_period = rp;
               shd_duty   = rd;
               shd_invert = cmd.invert;
               shd_enable = 1'b1;
               shd_valid  = 1'b1;
            end else begin
               act_period = rp;
               act_duty   = rd;
               act_invert = cmd.invert;
               act_enable = 1'b1;
               shd_valid  = 1'b0;
               set_level(rd != '0);
            end
         end
      end else if (ticks_left != '0) begin
         ticks_left--;
         if (ticks_left == '0) begin
            n_phase_ends++;
            // shadow settings load only at the end of a low phase
            if (!level && shd_valid) begin
               shd_valid  = 1'b0;
               act_period = shd_period;
               act_duty   = shd_duty;
               act_invert = shd_invert;
               act_enable = shd_enable;
               nxt        = (act_duty != '0);
            end else begin
               nxt = !level;
            end
            set_level(nxt);
         end
      end
      r.pins    = {PIN_WIDTH{pin_lvl}} & LANE_MASK[PIN_WIDTH-1:0];
      r.status  = rej;
      r.running = toggling;
      r.period  = shd_valid ? shd_period : act_period;
      r.duty    = shd_valid ? shd_duty : act_duty;
      r.invert  = shd_valid ? shd_invert : act_invert;
      r.enable  = shd_valid ? shd_enable : act_enable;
      return r;
   endfunction

   function automatic void add_write(input logic [DATA_WIDTH-1:0] p, input logic [DATA_WIDTH-1:0] d,
                                     input logic inv, input logic en);
      item_type c;
      c.op     = OP_WRITE;
      c.bad    = 1'b0;
      c.period = p;
      c.duty   = d;
      c.invert = inv;
      c.enable = en;
      pwm_commands.push_back(c);
   endfunction

   function automatic void add_tick();
      item_type c;
      c.op     = OP_TICK;
      c.bad    = 1'b0;
      c.period = $urandom();
      c.duty   = $urandom();
      c.invert = $urandom_range(0, 1);
      c.enable = $urandom_range(0, 1);
      pwm_commands.push_back(c);
   endfunction

   function automatic void add_random(input int count);
      logic [DATA_WIDTH-1:0] u, p, d;
      int                    units, k, pick;
      u = (res_reg == '0) ? 1 : DATA_WIDTH'(res_reg);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            add_tick();
         end else if (pick < 92) begin
            // settings on or near the resolution grid, with small periods so phases really end
            units = $urandom_range(1, 8);
            k     = $urandom_range(0, units);
            p     = u * units + $urandom_range(0, u - 1);
            d     = u * k;
            if (k != 0 && k != units && $urandom_range(0, 1))
               d = d + $urandom_range(0, u - 1);
            if (k == units && $urandom_range(0, 1))
               d = p;
            add_write(p, d, $urandom_range(0, 1), $urandom_range(0, 5) != 0);
         end else if (pick < 96) begin
            // malformed settings
            units = $urandom_range(1, 8);
            p     = u * units;
            if (u > 1 && $urandom_range(0, 1))
               d = $urandom_range(1, u - 1);
            else
               d = p + $urandom_range(1, 3);
            add_write(p, d, $urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            p = $urandom();
            d = $urandom_range(0, 1) ? $urandom() : p >> $urandom_range(0, 31);
            add_write(p, d, $urandom_range(0, 1), $urandom_range(0, 1));
         end
      end
   endfunction

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pwm_commands.size() != 0 || push || pwm_reports.size() != 0);
   endtask

   task automatic write_resolution(input logic [RES_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      res_reg = value;
      n_res_settings++;
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         req_taken = push && !full;
         rsp_taken = pop && !empty;
         if (rsp_taken) begin
            got_rpt.pins    = rsp_pins;
            got_rpt.status  = rsp_status;
            got_rpt.running = rsp_is_running;
            got_rpt.period  = rsp_rep_period;
            got_rpt.duty    = rsp_rep_duty;
            got_rpt.invert  = rsp_rep_invert;
            got_rpt.enable  = rsp_rep_enable;
            if (pwm_reports.size() == 0) begin
               $error("unexpected response transaction");
               mismatches++;
            end else begin
               exp_rpt = pwm_reports.pop_front();
               if (got_rpt.pins !== exp_rpt.pins) begin
                  $error("rsp_pins: expected %h, got %h", exp_rpt.pins, got_rpt.pins);
                  mismatches++;
               end
               if (got_rpt.status !== exp_rpt.status) begin
                  $error("rsp_status: expected %b, got %b", exp_rpt.status, got_rpt.status);
                  mismatches++;
               end
               if (got_rpt.running !== exp_rpt.running) begin
                  $error("rsp_is_running: expected %b, got %b",
                         exp_rpt.running, got_rpt.running);
                  mismatches++;
               end
               if (got_rpt.period !== exp_rpt.period) begin
                  $error("rsp_rep_period: expected %h, got %h",
                         exp_rpt.period, got_rpt.period);
                  mismatches++;
               end
               if (got_rpt.duty !== exp_rpt.duty) begin
                  $error("rsp_rep_duty: expected %h, got %h", exp_rpt.duty, got_rpt.duty);
                  mismatches++;
               end
               if (got_rpt.invert !== exp_rpt.invert) begin
                  $error("rsp_rep_invert: expected %b, got %b",
                         exp_rpt.invert, got_rpt.invert);
                  mismatches++;
               end
               if (got_rpt.enable !== exp_rpt.enable) begin
                  $error("rsp_rep_enable: expected %b, got %b",
                         exp_rpt.enable, got_rpt.enable);
                  mismatches++;
               end
            end
         end
         if (req_taken) begin
            seen_cmd.op     = op_type'(req_operation);
            seen_cmd.bad    = 1'b0;
            seen_cmd.period = req_period;
            seen_cmd.duty   = req_duty;
            seen_cmd.invert = req_invert;
            seen_cmd.enable = req_enable;
            pwm_reports.push_back(pwm_advance(seen_cmd));
            n_accepted++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (req_taken || !push) begin
         if (send_gap > 0) begin
            push <= 1'b0;
            send_gap--;
         end else if (pwm_commands.size() != 0) begin
            next_cmd = pwm_commands.pop_front();
            req_operation <= next_cmd.op;
            req_period    <= next_cmd.period;
            req_duty      <= next_cmd.duty;
            req_invert    <= next_cmd.invert;
            req_enable    <= next_cmd.enable;
            push          <= 1'b1;
            send_gap = calm ? 0 : $urandom_range(0, 9);
         end else begin
            push <= 1'b0;
         end
      end
   end

   // response consumer
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rsp_taken || !pop) begin
         if (pop_gap > 0) begin
            pop <= 1'b0;
            pop_gap--;
         end else begin
            pop <= 1'b1;
            pop_gap = calm ? 0 : $urandom_range(0, 9);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed transactions at the reset resolution
      add_tick();
      add_write(4, 1, 0, 1);
      add_tick();
      add_write(6, 6, 1, 1);
      add_write(8, 2, 1, 1);
      repeat (5) add_tick();
      add_write(7, 3, 0, 0);
      add_write(0, 0, 0, 1);
      add_write(5, 0, 1, 1);
      add_write(4, 5, 0, 1);
      add_write(ALL_ONES, ALL_ONES, 1, 1);
      add_write(ALL_ONES, 1, 0, 1);
      add_tick();
      add_write(ALL_ONES, 0, 1, 0);
      add_tick();
      add_random(300);

      wait_idle();
      write_resolution(16'd3);
      calm = 1'b1;
      add_write(10, 2, 0, 1);
      add_write(10, 8, 0, 1);
      add_write(2, 0, 0, 1);
      add_write(11, 4, 1, 1);
      add_tick();
      add_random(250);

      wait_idle();
      write_resolution(16'd0);
      calm = 1'b0;
      add_write(3, 1, 0, 1);
      add_random(200);

      wait_idle();
      write_resolution(16'hFFFF);
      add_write(ALL_ONES, 16'hFFFF, 0, 1);
      add_random(100);

      wait_idle();
      write_resolution(16'd2);
      calm = 1'b1;
      add_random(250);

      wait_idle();
      write_resolution(16'd5);
      calm = 1'b0;
      add_random(250);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d transactions over %0d resolution settings", n_accepted,
               n_res_settings);
      $display("settings writes %0d (rejected %0d), phase ends seen %0d", n_writes,
               n_rejects, n_phase_ends);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
